// File: hdl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg: shared definitions for the power-of-ten unit
// Widths, the table of decimal powers as binary64 patterns, and the
// sequencer states.
// ----------------------------------------------------------------------------
package dpt_pkg;

	localparam int unsigned EXP_W       = 10;
	localparam int unsigned MAG_W       = 9;
	localparam int unsigned VALUE_W     = 64;
	localparam int unsigned MAX_EXPONENT = 308;
	localparam int unsigned TAB_ENTRIES = 9;
	localparam int unsigned TAB_IDX_W   = 4;

	localparam logic [VALUE_W-1:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_MRND,
		ST_DIV,
		ST_DRND,
		ST_FINISH
	} state_t;

	// 10^(2^k) as binary64 bit patterns.
	function automatic logic [VALUE_W-1:0] tens_bits(input logic [TAB_IDX_W-1:0] idx);
		logic [VALUE_W-1:0] r;
		case (idx)
			4'd0:    r = 64'h4024_0000_0000_0000;
			4'd1:    r = 64'h4059_0000_0000_0000;
			4'd2:    r = 64'h40C3_8800_0000_0000;
			4'd3:    r = 64'h4197_D784_0000_0000;
			4'd4:    r = 64'h4341_C379_37E0_8000;
			4'd5:    r = 64'h4693_B8B5_B505_6E17;
			4'd6:    r = 64'h4D38_4F03_E93F_F9F5;
			4'd7:    r = 64'h5A82_7748_F930_1D32;
			4'd8:    r = 64'h7515_4FDD_7F73_BF3C;
			default: r = ONE_BITS;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/dpt_req_if.sv
// ----------------------------------------------------------------------------
// dpt_req_if: exponent request channel
// Valid/ready channel carrying one signed decimal exponent.
// ----------------------------------------------------------------------------
interface dpt_req_if;
	logic                          valid;
	logic                          ready;
	logic signed [dpt_pkg::EXP_W-1:0] exponent;

	modport source (output valid, output exponent, input ready);
	modport sink   (input valid, input exponent, output ready);
endinterface

// File: hdl/dpt_res_if.sv
// ----------------------------------------------------------------------------
// dpt_res_if: result channel
// Valid/ready channel carrying a binary64 pattern and a range flag.
// ----------------------------------------------------------------------------
interface dpt_res_if;
	logic                          valid;
	logic                          ready;
	logic [dpt_pkg::VALUE_W-1:0]   value_bits;
	logic                          range_error;

	modport source (output valid, output value_bits, output range_error, input ready);
	modport sink   (input valid, input value_bits, input range_error, output ready);
endinterface

// File: hdl/double_power_of_ten.sv
// ----------------------------------------------------------------------------
// double_power_of_ten: ten raised to a signed exponent, binary64 result
// Square-and-multiply over a table of 10^(2^k) with one shared 27x27
// multiplier, followed by a bit-serial reciprocal for negative exponents.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                       handshake
//  request  in   exponent[9:0] signed          valid/ready
//  result   out  value_bits[63:0], range_error valid/ready
//
//  Requests are taken one at a time; each magnitude bit is scanned, and each
//  set bit costs four partial products, a flush and a rounding step. A
//  negative exponent adds a restoring divide and rounding; an out-of-range
//  request goes straight to the output.
//  A request is taken only while idle; a finished result waits in the output
//  register on a stall. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module double_power_of_ten (
	input  logic      clk,
	input  logic      arst_n,
	dpt_req_if.sink   request,
	dpt_res_if.source result
);

	dpt_pkg::state_t state_q, state_d;

	logic [dpt_pkg::MAG_W-1:0]     mag_q;
	logic [dpt_pkg::TAB_IDX_W-1:0] k_q;
	logic                          neg_q;
	logic [dpt_pkg::VALUE_W-1:0]   acc_q;
	logic                          err_q;
	logic [2:0]                    mcnt_q;
	logic [53:0]                   pp_q;
	logic [105:0]                  prod_q;
	logic [5:0]                    dcnt_q;
	logic [53:0]                   rem_q;
	logic [53:0]                   quo_q;
	logic                          out_valid_q;
	logic [dpt_pkg::VALUE_W-1:0]   out_bits_q;
	logic                          out_err_q;

	// Request decode.
	logic [dpt_pkg::EXP_W:0] mag_in;
	logic                    neg_in;
	logic                    range_bad;
	assign neg_in    = request.exponent[dpt_pkg::EXP_W-1];
	assign mag_in    = neg_in ? (11'd1024 - {1'b0, request.exponent})
	                          : {1'b0, request.exponent};
	assign range_bad = mag_in > 11'(dpt_pkg::MAX_EXPONENT);

	// Shared multiplier operands.
	logic [dpt_pkg::VALUE_W-1:0] tab;
	logic [52:0] ma, mt;
	logic [26:0] op_a, op_b;
	assign tab = dpt_pkg::tens_bits(k_q);
	assign ma  = {1'b1, acc_q[51:0]};
	assign mt  = {1'b1, tab[51:0]};

	always_comb begin
		case (mcnt_q)
			3'd0:    begin op_a = ma[26:0];         op_b = mt[26:0];         end
			3'd1:    begin op_a = ma[26:0];         op_b = {1'b0, mt[52:27]}; end
			3'd2:    begin op_a = {1'b0, ma[52:27]}; op_b = mt[26:0];         end
			default: begin op_a = {1'b0, ma[52:27]}; op_b = {1'b0, mt[52:27]}; end
		endcase
	end

	logic [105:0] pp_ext;
	always_comb begin
		case (mcnt_q)
			3'd2, 3'd3: pp_ext = {52'b0, pp_q} << 27;
			3'd4:       pp_ext = {52'b0, pp_q} << 54;
			default:    pp_ext = {52'b0, pp_q};
		endcase
	end

	// Product rounding, nearest even; the carry of the increment runs into
	// the exponent field.
	logic [12:0] mexp;
	logic [51:0] mfrac;
	logic        mguard, msticky, mrnd;
	logic [dpt_pkg::VALUE_W-1:0] mres;
	always_comb begin
		mexp = 13'(acc_q[62:52]) + 13'(tab[62:52]) - 13'd1023 + 13'(prod_q[105]);
		if (prod_q[105]) begin
			mfrac   = prod_q[104:53];
			mguard  = prod_q[52];
			msticky = |prod_q[51:0];
		end else begin
			mfrac   = prod_q[103:52];
			mguard  = prod_q[51];
			msticky = |prod_q[50:0];
		end
		mrnd = mguard & (msticky | mfrac[0]);
		mres = {1'b0, mexp[10:0], mfrac} + 64'(mrnd);
	end

	// Reciprocal step and rounding.
	logic [53:0] r2;
	logic        qbit;
	logic [dpt_pkg::VALUE_W-1:0] dres;
	logic        drnd;
	logic [10:0] dexp;
	logic [51:0] dfrac;
	logic        dguard, dsticky;
	assign r2   = {rem_q[52:0], 1'b0};
	assign qbit = r2 >= {1'b0, ma};
	always_comb begin
		dexp    = 11'd2045 - acc_q[62:52];
		dfrac   = quo_q[52:1];
		dguard  = quo_q[0];
		dsticky = (rem_q != '0);
		// Products of 2^1022 and above have reciprocals below the normal
		// range, so the quotient is shifted down into the subnormal field.
		if (acc_q[62:52] == 11'd2046) begin
			dexp    = '0;
			dfrac   = {1'b0, quo_q[53:3]};
			dguard  = quo_q[2];
			dsticky = (rem_q != '0) | (|quo_q[1:0]);
		end else if (acc_q[62:52] == 11'd2045) begin
			dexp    = '0;
			dfrac   = quo_q[53:2];
			dguard  = quo_q[1];
			dsticky = (rem_q != '0) | quo_q[0];
		end
		drnd = dguard & (dsticky | dfrac[0]);
		if (acc_q[51:0] == '0) begin
			// A power of two inverts exactly.
			dres = {1'b0, 11'd2046 - acc_q[62:52], 52'b0};
		end else begin
			dres = {1'b0, dexp, dfrac} + 64'(drnd);
		end
	end

	assign request.ready      = (state_q == dpt_pkg::ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.value_bits  = out_bits_q;
	assign result.range_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dpt_pkg::ST_IDLE: begin
				if (request.valid) begin
					state_d = range_bad ? dpt_pkg::ST_FINISH : dpt_pkg::ST_SCAN;
				end
			end
			dpt_pkg::ST_SCAN: begin
				if (mag_q == '0) begin
					state_d = (neg_q && acc_q != dpt_pkg::ONE_BITS) ? dpt_pkg::ST_DIV
					                                               : dpt_pkg::ST_FINISH;
				end else if (mag_q[0]) begin
					state_d = dpt_pkg::ST_MUL;
				end
			end
			dpt_pkg::ST_MUL: begin
				if (mcnt_q == 3'd4) state_d = dpt_pkg::ST_MRND;
			end
			dpt_pkg::ST_MRND: state_d = dpt_pkg::ST_SCAN;
			dpt_pkg::ST_DIV: begin
				if (dcnt_q == 6'd53) state_d = dpt_pkg::ST_DRND;
			end
			dpt_pkg::ST_DRND: state_d = dpt_pkg::ST_FINISH;
			dpt_pkg::ST_FINISH: begin
				if (!out_valid_q || result.ready) state_d = dpt_pkg::ST_IDLE;
			end
			default: state_d = dpt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dpt_pkg::ST_FINISH && (!out_valid_q || result.ready)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dpt_pkg::ST_IDLE: begin
				mag_q <= mag_in[dpt_pkg::MAG_W-1:0];
				neg_q <= neg_in;
				k_q   <= '0;
				acc_q <= dpt_pkg::ONE_BITS;
				err_q <= range_bad;
			end
			dpt_pkg::ST_SCAN: begin
				mcnt_q <= '0;
				rem_q  <= 54'(1) << 52;
				dcnt_q <= '0;
				if (mag_q != '0 && !mag_q[0]) begin
					mag_q <= mag_q >> 1;
					k_q   <= k_q + 1'b1;
				end
			end
			dpt_pkg::ST_MUL: begin
				pp_q   <= 54'(op_a * op_b);
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == 3'd0) prod_q <= '0;
				else                prod_q <= prod_q + pp_ext;
			end
			dpt_pkg::ST_MRND: begin
				acc_q <= mres;
				mag_q <= mag_q >> 1;
				k_q   <= k_q + 1'b1;
			end
			dpt_pkg::ST_DIV: begin
				rem_q  <= qbit ? (r2 - {1'b0, ma}) : r2;
				quo_q  <= {quo_q[52:0], qbit};
				dcnt_q <= dcnt_q + 1'b1;
			end
			dpt_pkg::ST_DRND: acc_q <= dres;
			dpt_pkg::ST_FINISH: begin
				if (!out_valid_q || result.ready) begin
					out_bits_q <= acc_q;
					out_err_q  <= err_q;
				end
			end
			default: ;
		endcase
	end

endmodule
